### rtl/matrix_factor_sgd_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix factorization SGD block
// Immediate-implication and next-cycle-implication checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef MATRIX_FACTOR_SGD_UPDATE_ASSERT_SVH
`define MATRIX_FACTOR_SGD_UPDATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define MFSGD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfsgd: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define MFSGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfsgd: next-cycle check failed");

`else

`define MFSGD_ASSERT_IMPL(lbl, ante, cons)
`define MFSGD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/mfsgd_pkg.sv
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Shared constants, types and fixed-point helpers of the SGD factor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfsgd_pkg;

  // table geometry
  localparam int NUM_USERS  = 4096;
  localparam int NUM_ITEMS  = 1024;
  localparam int FACTORS    = 32;
  localparam int USER_W     = $clog2(NUM_USERS);
  localparam int ITEM_W     = $clog2(NUM_ITEMS);
  localparam int FACT_W     = $clog2(FACTORS);
  localparam int CNT_W      = FACT_W + 1;
  localparam int USER_AW    = USER_W + FACT_W;
  localparam int ITEM_AW    = ITEM_W + FACT_W;
  localparam int USER_DEPTH = NUM_USERS * FACTORS;
  localparam int ITEM_DEPTH = NUM_ITEMS * FACTORS;

  // shared multiplier geometry
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 38;

  // command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TRAIN   = 2'd1;
  localparam logic [1:0] CMD_PREDICT = 2'd2;

  // register indexes
  localparam logic CFG_LEARN_RATE = 1'b0;
  localparam logic CFG_REG_RATE   = 1'b1;

  localparam logic [15:0] LEARN_RATE_RST = 16'd1311;
  localparam logic [15:0] REG_RATE_RST   = 16'd0;

  // 1.0 and 5.0 in Q3.12
  localparam logic signed [15:0] ONE_Q  = 16'sd4096;
  localparam logic signed [15:0] FIVE_Q = 16'sd20480;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_DOT   = 8'b0000_1000,
    S_ERR   = 8'b0001_0000,
    S_UPD   = 8'b0010_0000,
    S_WB    = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic                       en;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

  // saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [MUL_P_W-1:0] x);
    logic signed [15:0] r;
    if (x > 52'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -52'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/matrix_factor_sgd_update.sv
// One item is in work at a time; the rate is set by the single shared multiplier,
// which walks the 32 factors for two dot products and two row updates (two
// products per element), plus the row fetch and write-back over the table ports.
// Reset clears control state and the configuration registers; factor tables are not cleared.
// ----------------------------------------------------------------------------
// matrix_factor_sgd_update
// Funk SVD SGD engine: factor loads, training steps and predictions in Q3.12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_factor_sgd_update_assert.svh"

module matrix_factor_sgd_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // user_index[11:0], item_index[21:12], rating[24:22], factor_index[29:25],
  // factor_value[45:30], zero fill [47:46]
  input  logic [47:0] s_axis_tdata_i,
  // cmd[1:0], table_select[2]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // raw_prediction[15:0], clamped_prediction[30:16], residual[46:31], zero [47]
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int FW = mfsgd_pkg::FACT_W;
  localparam int CW = mfsgd_pkg::CNT_W;
  localparam int PW = mfsgd_pkg::MUL_P_W;
  localparam int AW = mfsgd_pkg::MUL_A_W;
  localparam int BW = mfsgd_pkg::MUL_B_W;

  mfsgd_pkg::state_e state_q, state_d;
  logic [CW-1:0] k_q, k_d;
  logic          ph_q, ph_d;
  logic          pass_q;

  logic [1:0]                     cmd_q;
  logic [mfsgd_pkg::USER_W-1:0]   user_q;
  logic [mfsgd_pkg::ITEM_W-1:0]   item_q;
  logic [2:0]                     rating_q;
  logic                           tsel_q;
  logic [FW-1:0]                  fidx_q;
  logic signed [15:0]             fval_q;

  logic [15:0] learn_q, lambda_q;

  logic signed [15:0] urow_q [mfsgd_pkg::FACTORS];
  logic signed [15:0] vrow_q [mfsgd_pkg::FACTORS];

  logic signed [15:0] user_mem [mfsgd_pkg::USER_DEPTH];
  logic signed [15:0] item_mem [mfsgd_pkg::ITEM_DEPTH];
  logic signed [15:0] udata_q, vdata_q;
  logic               rd_v_q;
  logic [FW-1:0]      rd_k_q;

  mfsgd_pkg::mul_req_t mul_req;
  logic signed [PW-1:0] prod;
  logic                 pv;
  logic                 pph_q;
  logic [FW-1:0]        pk_q;

  logic signed [mfsgd_pkg::ACC_W-1:0] acc_q;
  logic signed [PW-1:0]               p1_q;
  logic [16:0]                        shrink_q;
  logic signed [AW-1:0]               er_q;
  logic signed [15:0]                 raw_q, res_out_q, resw_q;

  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic accept, k_run, out_load, dot_done, upd_fin;
  logic [FW-1:0] k_idx;
  logic signed [15:0] x_k, y_k;
  logic signed [mfsgd_pkg::ACC_W-1:0] acc_rnd, acc_sh;
  logic signed [15:0] dot_val, res_val, upd_val, clamp_val;
  logic signed [PW-1:0] res_wide, t_w, upd_sh;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == mfsgd_pkg::S_IDLE);
  assign k_run           = (k_q < CW'(mfsgd_pkg::FACTORS));
  assign k_idx           = k_q[FW-1:0];
  assign out_load        = (state_q == mfsgd_pkg::S_OUT) && (!out_valid_q || m_axis_tready_i);
  assign dot_done        = (state_q == mfsgd_pkg::S_DOT) && !k_run && !pv;
  assign upd_fin         = (state_q == mfsgd_pkg::S_UPD) && pv && pph_q;

  // pick the row being updated and the row it steps toward
  assign x_k = pass_q ? vrow_q[k_idx] : urow_q[k_idx];
  assign y_k = pass_q ? urow_q[k_idx] : vrow_q[k_idx];

  // round half up to Q3.12 and saturate the dot product
  assign acc_rnd  = acc_q + mfsgd_pkg::ACC_W'(2048);
  assign acc_sh   = acc_rnd >>> 12;
  assign dot_val  = mfsgd_pkg::sat16(PW'(acc_sh));
  assign res_wide = $signed({37'd0, rating_q, 12'd0}) - PW'(dot_val);
  assign res_val  = mfsgd_pkg::sat16(res_wide);

  // element update: shrink*x*4096 + er*y, rounded to Q3.12
  assign t_w     = (p1_q <<< 12) + prod;
  assign upd_sh  = (t_w + PW'(134217728)) >>> 28;
  assign upd_val = mfsgd_pkg::sat16(upd_sh);

  // clamp the prediction to 1.0..5.0
  always_comb begin
    if (raw_q < mfsgd_pkg::ONE_Q) begin
      clamp_val = mfsgd_pkg::ONE_Q;
    end else if (raw_q > mfsgd_pkg::FIVE_Q) begin
      clamp_val = mfsgd_pkg::FIVE_Q;
    end else begin
      clamp_val = raw_q;
    end
  end

  // drive the shared multiplier
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      mfsgd_pkg::S_DOT: begin
        mul_req.en = k_run;
        mul_req.a  = AW'(urow_q[k_idx]);
        mul_req.b  = BW'(vrow_q[k_idx]);
      end
      mfsgd_pkg::S_ERR: begin
        if (k_q == CW'(0)) begin
          mul_req.en = 1'b1;
          mul_req.a  = $signed({18'd0, learn_q});
          mul_req.b  = $signed({2'd0, lambda_q});
        end else if (k_q == CW'(1)) begin
          mul_req.en = 1'b1;
          mul_req.a  = AW'(resw_q);
          mul_req.b  = $signed({2'd0, learn_q});
        end
      end
      mfsgd_pkg::S_UPD: begin
        mul_req.en = k_run;
        if (!ph_q) begin
          mul_req.a = $signed({17'd0, shrink_q});
          mul_req.b = BW'(x_k);
        end else begin
          mul_req.a = er_q;
          mul_req.b = BW'(y_k);
        end
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  mfsgd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mul_req),
    .prod_o  (prod),
    .valid_o (pv)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ph_d    = ph_q;
    case (state_q)
      mfsgd_pkg::S_IDLE: begin
        k_d  = '0;
        ph_d = 1'b0;
        if (accept) begin
          if (s_axis_tuser_i[1:0] == mfsgd_pkg::CMD_LOAD) begin
            state_d = mfsgd_pkg::S_LOAD;
          end else if (s_axis_tuser_i[1:0] == mfsgd_pkg::CMD_TRAIN ||
                       s_axis_tuser_i[1:0] == mfsgd_pkg::CMD_PREDICT) begin
            state_d = mfsgd_pkg::S_FETCH;
          end else begin
            state_d = mfsgd_pkg::S_OUT;
          end
        end
      end
      mfsgd_pkg::S_LOAD: begin
        state_d = mfsgd_pkg::S_OUT;
      end
      mfsgd_pkg::S_FETCH: begin
        if (k_run) begin
          k_d = k_q + CW'(1);
        end else if (!rd_v_q) begin
          k_d     = '0;
          state_d = mfsgd_pkg::S_DOT;
        end
      end
      mfsgd_pkg::S_DOT: begin
        if (k_run) begin
          k_d = k_q + CW'(1);
        end else if (!pv) begin
          k_d = '0;
          if (!pass_q && cmd_q == mfsgd_pkg::CMD_PREDICT) begin
            state_d = mfsgd_pkg::S_OUT;
          end else begin
            state_d = mfsgd_pkg::S_ERR;
          end
        end
      end
      mfsgd_pkg::S_ERR: begin
        if (k_q == CW'(2)) begin
          k_d     = '0;
          ph_d    = 1'b0;
          state_d = mfsgd_pkg::S_UPD;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      mfsgd_pkg::S_UPD: begin
        if (k_run) begin
          ph_d = ~ph_q;
          if (ph_q) begin
            k_d = k_q + CW'(1);
          end
        end else if (!pv) begin
          k_d     = '0;
          state_d = pass_q ? mfsgd_pkg::S_WB : mfsgd_pkg::S_DOT;
        end
      end
      mfsgd_pkg::S_WB: begin
        if (k_run) begin
          k_d = k_q + CW'(1);
        end else begin
          state_d = mfsgd_pkg::S_OUT;
        end
      end
      mfsgd_pkg::S_OUT: begin
        if (out_load) begin
          state_d = mfsgd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mfsgd_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfsgd_pkg::S_IDLE;
      k_q         <= '0;
      ph_q        <= 1'b0;
      pass_q      <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      learn_q     <= mfsgd_pkg::LEARN_RATE_RST;
      lambda_q    <= mfsgd_pkg::REG_RATE_RST;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ph_q    <= ph_d;
      rd_v_q  <= (state_q == mfsgd_pkg::S_FETCH) && k_run;
      if (accept) begin
        pass_q <= 1'b0;
      end else if ((state_q == mfsgd_pkg::S_UPD) && !k_run && !pv) begin
        pass_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_index_i[0] == mfsgd_pkg::CFG_LEARN_RATE) begin
          learn_q <= cfg_data_i;
        end else begin
          lambda_q <= cfg_data_i;
        end
      end
    end
  end

  // capture the input word and working values
  always_ff @(posedge clk_i) begin
    pph_q  <= ph_q;
    pk_q   <= k_idx;
    rd_k_q <= k_idx;
    if (accept) begin
      cmd_q     <= s_axis_tuser_i[1:0];
      tsel_q    <= s_axis_tuser_i[2];
      user_q    <= s_axis_tdata_i[11:0];
      item_q    <= s_axis_tdata_i[21:12];
      rating_q  <= s_axis_tdata_i[24:22];
      fidx_q    <= s_axis_tdata_i[29:25];
      fval_q    <= s_axis_tdata_i[45:30];
      raw_q     <= '0;
      res_out_q <= '0;
    end
    // accumulate the dot product
    if (state_q == mfsgd_pkg::S_FETCH || state_q == mfsgd_pkg::S_UPD) begin
      acc_q <= '0;
    end else if (state_q == mfsgd_pkg::S_DOT && pv) begin
      acc_q <= acc_q + prod[mfsgd_pkg::ACC_W-1:0];
    end
    // residual at the end of each dot product
    if (dot_done) begin
      resw_q <= res_val;
      if (!pass_q) begin
        raw_q <= dot_val;
        if (cmd_q == mfsgd_pkg::CMD_TRAIN) begin
          res_out_q <= res_val;
        end
      end
    end
    // shrink and eta*residual
    if (state_q == mfsgd_pkg::S_ERR && k_q == CW'(1)) begin
      shrink_q <= 17'd65536 - {1'b0, prod[31:16]};
    end
    if (state_q == mfsgd_pkg::S_ERR && k_q == CW'(2)) begin
      er_q <= prod[AW-1:0];
    end
    // hold the shrink product of the current element
    if (state_q == mfsgd_pkg::S_UPD && pv && !pph_q) begin
      p1_q <= prod;
    end
    // fill rows from the tables, then update them in place
    if (rd_v_q) begin
      urow_q[rd_k_q] <= udata_q;
      vrow_q[rd_k_q] <= vdata_q;
    end else if (upd_fin) begin
      if (pass_q) begin
        vrow_q[pk_q] <= upd_val;
      end else begin
        urow_q[pk_q] <= upd_val;
      end
    end
    if (out_load) begin
      out_data_q <= {1'b0, res_out_q, clamp_val[14:0], raw_q};
    end
  end

  // user factor table
  always_ff @(posedge clk_i) begin
    if (state_q == mfsgd_pkg::S_LOAD && !tsel_q) begin
      user_mem[{user_q, fidx_q}] <= fval_q;
    end else if (state_q == mfsgd_pkg::S_WB && k_run) begin
      user_mem[{user_q, k_idx}] <= urow_q[k_idx];
    end
    udata_q <= user_mem[{user_q, k_idx}];
  end

  // item factor table
  always_ff @(posedge clk_i) begin
    if (state_q == mfsgd_pkg::S_LOAD && tsel_q) begin
      item_mem[{item_q, fidx_q}] <= fval_q;
    end else if (state_q == mfsgd_pkg::S_WB && k_run) begin
      item_mem[{item_q, k_idx}] <= vrow_q[k_idx];
    end
    vdata_q <= item_mem[{item_q, k_idx}];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `MFSGD_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready_o)
  `MFSGD_ASSERT_IMPL(a_clamp_range, out_valid_q, (out_data_q[30:16] >= 15'd4096) && (out_data_q[30:16] <= 15'd20480))
  `MFSGD_ASSERT_IMPL(a_count_bound, 1'b1, k_q <= CW'(mfsgd_pkg::FACTORS))
  `MFSGD_ASSERT_NEXT(a_result_shown, out_load, m_axis_tvalid_o)

endmodule

### rtl/mfsgd_mul.sv
// ----------------------------------------------------------------------------
// mfsgd_mul
// Shared signed multiplier with a registered product and valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfsgd_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfsgd_pkg::mul_req_t                 req_i,
  output logic signed [mfsgd_pkg::MUL_P_W-1:0] prod_o,
  output logic                                valid_o
);

  // register the product
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= req_i.a * req_i.b;
    end
  end

  // track which cycle carries a fresh product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= req_i.en;
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the SGD factor engine
// Drives load, train and predict words over the input stream, predicts each
// result word with a behavioral copy of the factor tables, and checks every
// field of the output stream under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NUSE = 2;  // users exercised
  localparam int NITM = 2;  // items exercised
  localparam int LIMIT = 2000000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        user_index;
    logic [9:0]         item_index;
    logic [2:0]         rating;
    logic               table_select;
    logic [4:0]         factor_index;
    logic signed [15:0] factor_value;
  } word_in_t;

  typedef struct packed {
    logic signed [15:0] raw_prediction;
    logic [14:0]        clamped_prediction;
    logic signed [15:0] residual;
  } word_out_t;

  typedef struct {
    word_in_t  w;
    bit        known;
    word_out_t r;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // predictor state
  logic signed [15:0] user_rows [mfsgd_pkg::NUM_USERS][mfsgd_pkg::FACTORS];
  logic signed [15:0] item_rows [mfsgd_pkg::NUM_ITEMS][mfsgd_pkg::FACTORS];
  bit user_set [mfsgd_pkg::NUM_USERS][mfsgd_pkg::FACTORS];
  bit item_set [mfsgd_pkg::NUM_ITEMS][mfsgd_pkg::FACTORS];
  logic [15:0] eta_q;
  logic [15:0] lambda_q;

  word_out_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  matrix_factor_sgd_update u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] sat_word(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  // floor(x / 2^s) with rounding half up applied by the caller
  function automatic longint floor_div(longint x, int s);
    return x >>> s;
  endfunction

  function automatic logic signed [15:0] row_dot(logic signed [15:0] a[mfsgd_pkg::FACTORS],
                                                 logic signed [15:0] b[mfsgd_pkg::FACTORS]);
    longint acc;
    acc = 0;
    for (int k = 0; k < mfsgd_pkg::FACTORS; k++) acc += longint'(a[k]) * longint'(b[k]);
    return sat_word(floor_div(acc + 2048, 12));
  endfunction

  function automatic void shrink_step(ref logic signed [15:0] x[mfsgd_pkg::FACTORS],
                                      input logic signed [15:0] y[mfsgd_pkg::FACTORS],
                                      input longint shrink, input longint res);
    longint er, t;
    er = longint'(eta_q) * res;
    for (int k = 0; k < mfsgd_pkg::FACTORS; k++) begin
      t = shrink * longint'(x[k]) * 4096 + er * longint'(y[k]);
      x[k] = sat_word(floor_div(t + (longint'(1) << 27), 28));
    end
  endfunction

  // true once every element of the row has been loaded
  function automatic bit user_full(int u);
    for (int k = 0; k < mfsgd_pkg::FACTORS; k++) if (!user_set[u][k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit item_full(int i);
    for (int k = 0; k < mfsgd_pkg::FACTORS; k++) if (!item_set[i][k]) return 1'b0;
    return 1'b1;
  endfunction

  // compute the result word and advance the tables
  function automatic word_out_t sgd_predict(word_in_t w);
    word_out_t r;
    logic signed [15:0] ur[mfsgd_pkg::FACTORS];
    logic signed [15:0] vr[mfsgd_pkg::FACTORS];
    longint raw, shrink, res2;
    r.raw_prediction = '0;
    r.clamped_prediction = 15'd4096;
    r.residual = '0;
    if (w.cmd == mfsgd_pkg::CMD_LOAD) begin
      if (w.table_select == 1'b0) begin
        user_rows[w.user_index][w.factor_index] = w.factor_value;
        user_set[w.user_index][w.factor_index] = 1'b1;
      end else begin
        item_rows[w.item_index][w.factor_index] = w.factor_value;
        item_set[w.item_index][w.factor_index] = 1'b1;
      end
    end else if (w.cmd == mfsgd_pkg::CMD_TRAIN || w.cmd == mfsgd_pkg::CMD_PREDICT) begin
      for (int k = 0; k < mfsgd_pkg::FACTORS; k++) begin
        ur[k] = user_rows[w.user_index][k];
        vr[k] = item_rows[w.item_index][k];
      end
      raw = row_dot(ur, vr);
      r.raw_prediction = raw[15:0];
      r.clamped_prediction = raw < 4096 ? 15'd4096 : (raw > 20480 ? 15'd20480 : raw[14:0]);
      if (w.cmd == mfsgd_pkg::CMD_TRAIN) begin
        shrink = 65536 - longint'((longint'(eta_q) * longint'(lambda_q)) >> 16);
        r.residual = sat_word(longint'(w.rating) * 4096 - raw);
        shrink_step(ur, vr, shrink, longint'(r.residual));
        res2 = sat_word(longint'(w.rating) * 4096 - longint'(row_dot(ur, vr)));
        shrink_step(vr, ur, shrink, res2);
        for (int k = 0; k < mfsgd_pkg::FACTORS; k++) begin
          user_rows[w.user_index][k] = ur[k];
          item_rows[w.item_index][k] = vr[k];
        end
      end
    end
    return r;
  endfunction

  // send one word, keeping valid high across back-to-back words
  task automatic send_word(word_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, w.factor_value, w.factor_index, w.rating,
                       w.item_index, w.user_index};
    s_axis_tuser_i <= {w.table_select, w.cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drop_valid();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    drop_valid();
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mfsgd_pkg::CFG_LEARN_RATE) eta_q = val;
    else lambda_q = val;
    @(posedge clk_i);
  endtask

  // record expectations on accepted input words
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      word_in_t w;
      w.cmd = s_axis_tuser_i[1:0];
      w.table_select = s_axis_tuser_i[2];
      {w.factor_value, w.factor_index, w.rating, w.item_index, w.user_index} =
        s_axis_tdata_i[45:0];
      expected_words.push_back(sgd_predict(w));
    end
  end

  // random receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // compare output words with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      word_out_t got, exp_w;
      got.raw_prediction = m_axis_tdata_o[15:0];
      got.clamped_prediction = m_axis_tdata_o[30:16];
      got.residual = m_axis_tdata_o[46:31];
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.raw_prediction !== exp_w.raw_prediction) begin
          $error("raw_prediction exp %0d got %0d", exp_w.raw_prediction, got.raw_prediction);
          errors++;
        end
        if (got.clamped_prediction !== exp_w.clamped_prediction) begin
          $error("clamped_prediction exp %0d got %0d", exp_w.clamped_prediction,
                 got.clamped_prediction);
          errors++;
        end
        if (got.residual !== exp_w.residual) begin
          $error("residual exp %0d got %0d", exp_w.residual, got.residual);
          errors++;
        end
        if (m_axis_tdata_o[47] !== 1'b0) begin
          $error("pad bit exp 0 got %b", m_axis_tdata_o[47]);
          errors++;
        end
      end
    end
  end

  function automatic word_in_t mk(logic [1:0] c, int u, int i, int rt, int sel, int f,
                                  int v);
    word_in_t w;
    w.cmd = c; w.user_index = 12'(u); w.item_index = 10'(i); w.rating = 3'(rt);
    w.table_select = 1'(sel); w.factor_index = 5'(f); w.factor_value = 16'(v);
    return w;
  endfunction

  function automatic stim_row_t row(word_in_t w, bit known, int raw, int clamp, int res);
    stim_row_t s;
    s.w = w; s.known = known;
    s.r.raw_prediction = 16'(raw); s.r.clamped_prediction = 15'(clamp);
    s.r.residual = 16'(res);
    return s;
  endfunction

  // random word, mostly on a small row set; train and predict read only fully loaded rows
  function automatic word_in_t rand_word();
    word_in_t w;
    int pick;
    w = '0;
    w.user_index = 12'($urandom_range(NUSE - 1));
    w.item_index = 10'($urandom_range(NITM - 1));
    if ($urandom_range(19) == 0) w.user_index = 12'($urandom_range(4095));
    if ($urandom_range(19) == 0) w.item_index = 10'($urandom_range(1023));
    w.rating = 3'($urandom_range(7));
    w.table_select = 1'($urandom_range(1));
    w.factor_index = 5'($urandom_range(31));
    w.factor_value = $urandom_range(99) < 80 ? 16'($urandom_range(16383) - 8192)
                                             : 16'($urandom_range(65535));
    pick = $urandom_range(99);
    w.cmd = pick < 30 ? mfsgd_pkg::CMD_LOAD :
            (pick < 70 ? mfsgd_pkg::CMD_TRAIN :
             (pick < 96 ? mfsgd_pkg::CMD_PREDICT : CMD_SPARE));
    // never read rows that were not loaded
    if (w.cmd == mfsgd_pkg::CMD_TRAIN || w.cmd == mfsgd_pkg::CMD_PREDICT)
      if (!user_full(w.user_index) || !item_full(w.item_index)) w.cmd = mfsgd_pkg::CMD_LOAD;
    return w;
  endfunction

  stim_row_t dir_rows[$];

  initial begin
    word_in_t w;
    eta_q = mfsgd_pkg::LEARN_RATE_RST;
    lambda_q = mfsgd_pkg::REG_RATE_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the exercised rows fully so no unwritten entry is read
    for (int u = 0; u < NUSE; u++)
      for (int f = 0; f < mfsgd_pkg::FACTORS; f++)
        send_word(mk(mfsgd_pkg::CMD_LOAD, u, 0, 0, 0, f, $urandom_range(8191) - 4096));
    for (int i = 0; i < NITM; i++)
      for (int f = 0; f < mfsgd_pkg::FACTORS; f++)
        send_word(mk(mfsgd_pkg::CMD_LOAD, 0, i, 0, 1, f, $urandom_range(8191) - 4096));
    // extreme rows: user 4095 all max, item 1023 all min
    for (int f = 0; f < mfsgd_pkg::FACTORS; f++) begin
      send_word(mk(mfsgd_pkg::CMD_LOAD, 4095, 0, 0, 0, f, 32767));
      send_word(mk(mfsgd_pkg::CMD_LOAD, 0, 1023, 0, 1, f, -32768));
    end
    wait_drain();

    // directed table
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_LOAD, 1, 1, 5, 0, 31, 32767), 1, 0, 4096, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_LOAD, 1, 1, 5, 1, 31, -32768), 1, 0, 4096, 0));
    dir_rows.push_back(row(mk(CMD_SPARE, 4095, 1023, 7, 1, 31, -1), 1, 0, 4096, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_PREDICT, 4095, 1023, 0, 0, 0, 0), 1, -32768,
                           4096, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_PREDICT, 4095, 1, 0, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_PREDICT, 1, 1, 0, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 1, 1, 5, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 0, 1, 1, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 1, 0, 0, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 1, 1, 7, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 4095, 1023, 6, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_PREDICT, 4095, 1023, 0, 1, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0), 1, 0, 4096, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_PREDICT, 0, 0, 3, 0, 0, 0), 0, 0, 0, 0));
    dir_rows.push_back(row(mk(mfsgd_pkg::CMD_TRAIN, 0, 0, 3, 1, 0, 0), 0, 0, 0, 0));
    foreach (dir_rows[n]) begin
      send_word(dir_rows[n].w);
      if (dir_rows[n].known) begin
        // let the accepted word reach the expectation queue
        @(posedge clk_i);
        // table value must agree with the predictor
        if (expected_words[$] !== dir_rows[n].r) begin
          $error("directed row %0d: expected word %h, predicted %h", n,
                 dir_rows[n].r, expected_words[$]);
          errors++;
        end
      end
    end
    wait_drain();

    // random phases across register settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(mfsgd_pkg::CFG_LEARN_RATE, 16'd0);
          write_reg(mfsgd_pkg::CFG_REG_RATE, 16'd0);
        end
        1: begin
          write_reg(mfsgd_pkg::CFG_LEARN_RATE, 16'd65535);
          write_reg(mfsgd_pkg::CFG_REG_RATE, 16'd65535);
        end
        2: begin
          write_reg(mfsgd_pkg::CFG_LEARN_RATE, 16'd1311);
          write_reg(mfsgd_pkg::CFG_REG_RATE, 16'd655);
        end
        default: begin
          write_reg(mfsgd_pkg::CFG_LEARN_RATE, 16'($urandom_range(4000)));
          write_reg(mfsgd_pkg::CFG_REG_RATE, 16'($urandom_range(65535)));
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int n = 0; n < 25; n++) begin
        w = rand_word();
        send_word(w);
        if (n == 12) wait_drain();
      end
      wait_drain();
    end

    // final settle with a bound
    drop_valid();
    for (int n = 0; n < 2000 && expected_words.size() != 0; n++) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
